### rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int ACTION_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  // common width for comparing positions, counts and the capacity limit
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CMP_W-1:0]    cmp_t;

  localparam action_t ACT_INSERT = 3'd0;
  localparam action_t ACT_REMOVE = 3'd1;
  localparam action_t ACT_APPEND = 3'd2;
  localparam action_t ACT_SEARCH = 3'd3;
  localparam action_t ACT_UPDATE = 3'd4;
  localparam action_t ACT_READ   = 3'd5;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  function automatic cmp_t limit_of(input logic [CAP_W-1:0] cap);
    cmp_t cap_x;
    cmp_t max_x;
    cap_x = CMP_W'(cap);
    max_x = CMP_W'(MAX_ENTRIES);
    return (cap_x < max_x) ? cap_x : max_x;
  endfunction

endpackage

### rtl/core/ple_ifs.sv
interface ple_req_if
  import ple_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_rsp_if
  import ple_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [FOUND_W-1:0]        found_index;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, status, found_index, read_value, count, input ready);
  modport sink   (input valid, status, found_index, read_value, count, output ready);
endinterface

interface ple_cfg_if
  import ple_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/positional_list_engine.sv
// channel   port     dir  payload
// request   in_ch    in   action, position, value
// response  out_ch   out  status, found_index, read_value, count
// config    cfg_ch   in   data (capacity), always ready
//
// append, update and error cases go from idle straight to the final state; read passes through a read state
// insert shifts entries up from the end down to the position, remove shifts them down from the position;
// search compares entries from index zero until a match or the last entry; one store entry moves or compares per cycle
// the entry store has a single read port and a single write port
// rst_n is synchronous; it empties the list and sets capacity to 64
// a new request is taken only when the sequencer is idle; a held result
// stalls the sequencer in its final state until the output register frees
module positional_list_engine
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ple_req_if.sink   in_ch,
  ple_rsp_if.source out_ch,
  ple_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_UP = 3'd1;
  localparam logic [2:0] S_SHIFT_DN = 3'd2;
  localparam logic [2:0] S_SEARCH   = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [VALUE_W-1:0] mem [MAX_ENTRIES];
  logic [VALUE_W-1:0] rd_data_r;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [2:0]         state_r,     state_nxt;
  logic [CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic [CAP_W-1:0]   cap_r,       cap_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  idx_r,       idx_nxt;
  logic [ADDR_W-1:0]  pos_r,       pos_nxt;
  logic [VALUE_W-1:0] val_r,       val_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_found_r,  res_found_nxt;
  logic [VALUE_W-1:0] res_value_r,  res_value_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [FOUND_W-1:0] out_found_r,  out_found_nxt;
  logic [VALUE_W-1:0] out_value_r,  out_value_nxt;
  logic [COUNT_W-1:0] out_count_r,  out_count_nxt;

  logic in_xfer;
  cmp_t cnt_x;
  cmp_t pos_x;
  cmp_t lim_x;
  cmp_t idx_inc_x;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.count       = out_count_r;

  assign cnt_x     = CMP_W'(cnt_r);
  assign pos_x     = CMP_W'(in_ch.position);
  assign lim_x     = limit_of(cap_r);
  assign idx_inc_x = CMP_W'(idx_r) + CMP_W'(1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = idx_r;

    if (cfg_ch.valid) begin
      cap_nxt = cfg_ch.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          res_value_nxt  = '0;
          val_nxt        = in_ch.value;
          pos_nxt        = ADDR_W'(in_ch.position);
          state_nxt      = S_DONE;
          unique case (in_ch.action)
            ACT_INSERT: begin
              if (cnt_x >= lim_x) begin
                res_status_nxt = ST_FULL;
              end else if (pos_x > cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = ADDR_W'(cnt_r);
                mem_raddr = ADDR_W'(cnt_r) - ADDR_W'(1);
                state_nxt = S_SHIFT_UP;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = ADDR_W'(in_ch.position);
                mem_raddr = ADDR_W'(in_ch.position) + ADDR_W'(1);
                state_nxt = S_SHIFT_DN;
              end
            end
            ACT_APPEND: begin
              if (cnt_x >= lim_x) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_r);
                mem_wdata = in_ch.value;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            ACT_SEARCH: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                mem_raddr = '0;
                state_nxt = S_SEARCH;
              end
            end
            ACT_UPDATE: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(in_ch.position);
                mem_wdata = in_ch.value;
              end
            end
            ACT_READ: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_raddr = ADDR_W'(in_ch.position);
                state_nxt = S_READ;
              end
            end
            default: begin
              res_status_nxt = ST_RANGE;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        // read data holds the entry just below idx_r
        mem_we = 1'b1;
        if (idx_r == pos_r) begin
          mem_waddr = pos_r;
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_waddr = idx_r;
          mem_wdata = rd_data_r;
          mem_raddr = idx_r - ADDR_W'(2);
          idx_nxt   = idx_r - ADDR_W'(1);
        end
      end
      S_SHIFT_DN: begin
        // read data holds the entry just above idx_r
        if (idx_inc_x == cnt_x) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = rd_data_r;
          mem_raddr = idx_r + ADDR_W'(2);
          idx_nxt   = idx_r + ADDR_W'(1);
        end
      end
      S_SEARCH: begin
        if (rd_data_r == val_r) begin
          res_found_nxt = idx_r;
          state_nxt     = S_DONE;
        end else if (idx_inc_x == cnt_x) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          mem_raddr = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
        end
      end
      S_READ: begin
        res_value_nxt = rd_data_r;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = FOUND_W'(res_found_r);
          out_value_nxt  = res_value_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CMP_W'(MAX_ENTRIES))
    else $error("entry count above store depth");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("sequencer idle right after a request transfer");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised outside the final state");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) && $past(rst_n) |->
      (cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");
`endif

endmodule
